/* rtl/gha_pkg.sv */
// shared constants, codes and types of the generational handle allocator
package gha_pkg;

    localparam int unsigned DEF_SLOTS           = 1024;
    localparam int unsigned DEF_GENERATION_BITS = 16;
    localparam int unsigned DEF_GROUP_BITS      = 8;
    localparam int unsigned DEF_POSITION_BITS   = 16;

    // operation codes
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;
    localparam logic [1:0] OP_RELOCATE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the item and read its slot
        logic commit;   // update the slot and load the result register
    } t_cmd;

endpackage

/* rtl/generational_handle_allocator.sv */
// top level of the generational handle allocator
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_op, i_handle_in, i_group_in, i_position_in
//  out     | output    | o_out_valid / i_out_stall | o_status, o_handle_out, o_group_out,
//          |           |                           |   o_position_out
//
//  each operation has a transfer step, which reads the slot from the slot memory, and an
//  update step, which does the update write and loads the result register.
//  one operation is in flight at a time; a new transfer is taken only once the last is done.
//  reset empties the table and the free list; slot memory needs no clearing pass.
//  a stalled result holds the update cycle until the result register drains.
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int unsigned SLOTS           = DEF_SLOTS,
    parameter int unsigned GENERATION_BITS = DEF_GENERATION_BITS,
    parameter int unsigned GROUP_BITS      = DEF_GROUP_BITS,
    parameter int unsigned POSITION_BITS   = DEF_POSITION_BITS,
    localparam int unsigned HANDLE_BITS    = $clog2(SLOTS) + GENERATION_BITS
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [HANDLE_BITS-1:0]   i_handle_in,
    input  logic [GROUP_BITS-1:0]    i_group_in,
    input  logic [POSITION_BITS-1:0] i_position_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [HANDLE_BITS-1:0]   o_handle_out,
    output logic [GROUP_BITS-1:0]    o_group_out,
    output logic [POSITION_BITS-1:0] o_position_out
);

    t_cmd cmd;

    gha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    gha_datapath #(
        .SLOTS           (SLOTS),
        .GENERATION_BITS (GENERATION_BITS),
        .GROUP_BITS      (GROUP_BITS),
        .POSITION_BITS   (POSITION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_handle_in    (i_handle_in),
        .i_group_in     (i_group_in),
        .i_position_in  (i_position_in),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_group_out    (o_group_out),
        .o_position_out (o_position_out)
    );

endmodule

/* rtl/gha_ctrl.sv */
// controller state machine of the generational handle allocator
module gha_ctrl
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // result register free or drained this cycle
    logic can_load;

    assign can_load      = !r_out_valid || !i_out_stall;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit  = (r_state == S_EXEC) && can_load;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/gha_datapath.sv */
// slot memory, free list head, slot counter and result register
module gha_datapath
    import gha_pkg::*;
#(
    parameter int unsigned SLOTS           = DEF_SLOTS,
    parameter int unsigned GENERATION_BITS = DEF_GENERATION_BITS,
    parameter int unsigned GROUP_BITS      = DEF_GROUP_BITS,
    parameter int unsigned POSITION_BITS   = DEF_POSITION_BITS,
    localparam int unsigned INDEX_BITS     = $clog2(SLOTS),
    localparam int unsigned HANDLE_BITS    = INDEX_BITS + GENERATION_BITS
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [1:0]                 i_op,
    input  logic [HANDLE_BITS-1:0]     i_handle_in,
    input  logic [GROUP_BITS-1:0]      i_group_in,
    input  logic [POSITION_BITS-1:0]   i_position_in,
    output logic [1:0]                 o_status,
    output logic [HANDLE_BITS-1:0]     o_handle_out,
    output logic [GROUP_BITS-1:0]      o_group_out,
    output logic [POSITION_BITS-1:0]   o_position_out
);

    localparam int unsigned HEAD_BITS = $clog2(SLOTS + 1);
    // position field doubles as the free list link
    localparam int unsigned LINK_BITS =
        (POSITION_BITS > HEAD_BITS) ? POSITION_BITS : HEAD_BITS;

    typedef struct packed {
        logic                       live;
        logic [GENERATION_BITS-1:0] gen;
        logic [GROUP_BITS-1:0]      grp;
        logic [LINK_BITS-1:0]       link;
    } t_slot;

    t_slot r_mem [SLOTS];
    t_slot r_rd;

    logic [HEAD_BITS-1:0]     r_used;
    logic [HEAD_BITS-1:0]     r_head;
    logic [1:0]               r_op;
    logic [HANDLE_BITS-1:0]   r_handle;
    logic [GROUP_BITS-1:0]    r_group;
    logic [POSITION_BITS-1:0] r_position;

    logic [1:0]               r_status;
    logic [HANDLE_BITS-1:0]   r_handle_out;
    logic [GROUP_BITS-1:0]    r_group_out;
    logic [POSITION_BITS-1:0] r_position_out;

    logic [INDEX_BITS-1:0]      rd_addr;
    logic [INDEX_BITS-1:0]      idx;
    logic [GENERATION_BITS-1:0] gen;
    logic                       head_valid;

    logic [HEAD_BITS-1:0]     n_used;
    logic [HEAD_BITS-1:0]     n_head;
    logic                     wr_en;
    logic [INDEX_BITS-1:0]    wr_addr;
    t_slot                    wr_data;
    logic [1:0]               n_status;
    logic [HANDLE_BITS-1:0]   n_handle_out;
    logic [GROUP_BITS-1:0]    n_group_out;
    logic [POSITION_BITS-1:0] n_position_out;

    assign head_valid = (r_head < HEAD_BITS'(SLOTS));

    always_comb begin
        if (i_op == OP_ALLOC) begin
            rd_addr = head_valid ? r_head[INDEX_BITS-1:0] : r_used[INDEX_BITS-1:0];
        end else begin
            rd_addr = i_handle_in[INDEX_BITS-1:0];
        end
    end

    assign idx = r_handle[INDEX_BITS-1:0];
    assign gen = r_handle[HANDLE_BITS-1:INDEX_BITS];

    always_comb begin
        n_used         = r_used;
        n_head         = r_head;
        wr_en          = 1'b0;
        wr_addr        = idx;
        wr_data        = r_rd;
        n_status       = ST_OK;
        n_handle_out   = r_handle;
        n_group_out    = '0;
        n_position_out = '0;

        case (r_op)
            OP_ALLOC: begin
                wr_data.live = 1'b1;
                wr_data.grp  = r_group;
                wr_data.link = LINK_BITS'(r_position);
                if (head_valid) begin
                    // pop the free list
                    wr_en   = 1'b1;
                    wr_addr = r_head[INDEX_BITS-1:0];
                    if (r_rd.link > LINK_BITS'(SLOTS)) begin
                        n_head = HEAD_BITS'(SLOTS);
                    end else begin
                        n_head = r_rd.link[HEAD_BITS-1:0];
                    end
                end else if (r_used < HEAD_BITS'(SLOTS)) begin
                    // fresh slot
                    wr_en       = 1'b1;
                    wr_addr     = r_used[INDEX_BITS-1:0];
                    wr_data.gen = GENERATION_BITS'(1);
                    n_used      = r_used + HEAD_BITS'(1);
                end else begin
                    n_status = ST_FULL;
                end
                if (wr_en) begin
                    n_handle_out = {wr_data.gen, wr_addr};
                end
            end
            default: begin
                if (HEAD_BITS'(idx) >= r_used) begin
                    n_status = ST_RANGE;
                end else if (!r_rd.live || r_rd.gen != gen) begin
                    n_status = ST_STALE;
                end else begin
                    case (r_op)
                        OP_FREE: begin
                            wr_en        = 1'b1;
                            wr_data.live = 1'b0;
                            wr_data.gen  = r_rd.gen + GENERATION_BITS'(1);
                            wr_data.link = LINK_BITS'(r_head);
                            n_head       = HEAD_BITS'(idx);
                        end
                        OP_LOOKUP: begin
                            n_group_out    = r_rd.grp;
                            n_position_out = r_rd.link[POSITION_BITS-1:0];
                        end
                        OP_RELOCATE: begin
                            wr_en        = 1'b1;
                            wr_data.grp  = r_group;
                            wr_data.link = LINK_BITS'(r_position);
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
        endcase
    end

    // slot memory: one read at capture, at most one write at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd <= r_mem[rd_addr];
        end
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_head <= HEAD_BITS'(SLOTS);
        end else if (i_cmd.commit) begin
            r_used <= n_used;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_op;
            r_handle   <= i_handle_in;
            r_group    <= i_group_in;
            r_position <= i_position_in;
        end
        if (i_cmd.commit) begin
            r_status       <= n_status;
            r_handle_out   <= n_handle_out;
            r_group_out    <= n_group_out;
            r_position_out <= n_position_out;
        end
    end

    assign o_status       = r_status;
    assign o_handle_out   = r_handle_out;
    assign o_group_out    = r_group_out;
    assign o_position_out = r_position_out;

endmodule

/* rtl/gha_checker.sv */
// port level checks of the generational handle allocator and their bind
module gha_sva #(
    parameter int unsigned HANDLE_BITS   = 26,
    parameter int unsigned GROUP_BITS    = 8,
    parameter int unsigned POSITION_BITS = 16
)
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [1:0]               o_status,
    input logic [HANDLE_BITS-1:0]   o_handle_out,
    input logic [GROUP_BITS-1:0]    o_group_out,
    input logic [POSITION_BITS-1:0] o_position_out
);

    // an accepted item keeps the input side busy for the update cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not busy after transfer");

    // a new result only comes out of an item in flight
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in flight");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_status) && $stable(o_handle_out)
            && $stable(o_group_out) && $stable(o_position_out)))
        else $error("result changed while stalled");

endmodule

bind generational_handle_allocator gha_sva #(
    .HANDLE_BITS   (HANDLE_BITS),
    .GROUP_BITS    (GROUP_BITS),
    .POSITION_BITS (POSITION_BITS)
) u_gha_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_handle_out   (o_handle_out),
    .o_group_out    (o_group_out),
    .o_position_out (o_position_out)
);
